// File: rtl/icmp_echo_pkg.sv
package icmp_echo_pkg;

  // Byte offsets within the IPv4 header and the ICMP header that follows it
  localparam logic [15:0] OffTotLen     = 16'd3;
  localparam logic [15:0] OffProto      = 16'd9;
  localparam logic [15:0] OffHdrCsum    = 16'd11;
  localparam logic [15:0] OffDstFirst   = 16'd16;
  localparam logic [15:0] HdrBytes      = 16'd20;
  localparam logic [15:0] OffIcmpType   = 16'd20;
  localparam logic [15:0] OffIcmpCsumHi = 16'd22;
  localparam logic [15:0] OffIcmpCsumLo = 16'd23;
  localparam logic [15:0] MinBytes      = 16'd24;
  localparam logic [15:0] CountMax      = 16'hFFFF;

  localparam logic [7:0]  IcmpProto      = 8'h01;
  localparam logic [7:0]  EchoRequest    = 8'h08;
  localparam logic [31:0] LocalAddrReset = 32'h0A00_0002;
  localparam logic [15:0] OnesAllSet     = 16'hFFFF;

  // Verdict codes
  localparam logic [2:0] StAccepted   = 3'd0;
  localparam logic [2:0] StEchoReply  = 3'd1;
  localparam logic [2:0] StBadHdrCsum = 3'd2;
  localparam logic [2:0] StWrongDest  = 3'd3;
  localparam logic [2:0] StLengthErr  = 3'd4;

  // Summary queue between front and back; depth must be a power of two
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic        len_err;
    logic        dest_ok;
    logic        is_echo;
    logic [19:0] hdr_sum;
    logic [15:0] hdr_csum;
    logic [31:0] icmp_sum;
  } pkt_summary_t;

  // Two-pass end-around carry fold to 16 bits
  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    s2 = {1'b0, s1[15:0]} + {16'b0, s1[16]};
    return s2[15:0];
  endfunction

endpackage

// File: rtl/icmp_echo_front.sv
module icmp_echo_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [31:0]                 cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  input  logic                        q_full,
  output logic                        push,
  output icmp_echo_pkg::pkt_summary_t push_data
);

  logic [31:0] local_addr;
  logic [15:0] byte_count, byte_count_next;
  logic [19:0] header_sum, header_sum_next;
  logic [31:0] icmp_sum, icmp_sum_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic        dest_match, dest_match_next;
  logic [7:0]  protocol_byte, protocol_byte_next;
  logic [7:0]  icmp_type_byte, icmp_type_byte_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] header_csum, header_csum_next;
  logic [15:0] word;
  logic [7:0]  addr_byte;
  logic        take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign push     = take && in_last;
  assign word     = {high_byte_hold, in_byte};

  always_comb begin
    case (byte_count[1:0])
      2'd0:    addr_byte = local_addr[31:24];
      2'd1:    addr_byte = local_addr[23:16];
      2'd2:    addr_byte = local_addr[15:8];
      default: addr_byte = local_addr[7:0];
    endcase
  end

  always_comb begin
    byte_count_next     = byte_count;
    header_sum_next     = header_sum;
    icmp_sum_next       = icmp_sum;
    high_byte_hold_next = high_byte_hold;
    dest_match_next     = dest_match;
    protocol_byte_next  = protocol_byte;
    icmp_type_byte_next = icmp_type_byte;
    total_length_next   = total_length;
    header_csum_next    = header_csum;

    if (byte_count < icmp_echo_pkg::HdrBytes) begin
      if (!byte_count[0]) begin
        high_byte_hold_next = in_byte;
      end else begin
        if (byte_count == icmp_echo_pkg::OffHdrCsum) begin
          header_csum_next = word;
        end else begin
          header_sum_next = header_sum + {4'b0, word};
        end
        if (byte_count == icmp_echo_pkg::OffTotLen) begin
          total_length_next = word;
        end
      end
      if (byte_count == icmp_echo_pkg::OffProto) begin
        protocol_byte_next = in_byte;
      end
      if (byte_count >= icmp_echo_pkg::OffDstFirst && addr_byte != in_byte) begin
        dest_match_next = 1'b0;
      end
    end

    if (byte_count == icmp_echo_pkg::OffIcmpType) begin
      icmp_type_byte_next = in_byte;
    end

    // Type byte and the checksum field count as zero
    if (byte_count > icmp_echo_pkg::OffIcmpType && byte_count < total_length &&
        byte_count != icmp_echo_pkg::OffIcmpCsumHi &&
        byte_count != icmp_echo_pkg::OffIcmpCsumLo) begin
      icmp_sum_next = icmp_sum +
                      (byte_count[0] ? {24'b0, in_byte} : {16'b0, in_byte, 8'b0});
    end

    if (byte_count != icmp_echo_pkg::CountMax) begin
      byte_count_next = byte_count + 16'd1;
    end
  end

  always_comb begin
    push_data.len_err  = (byte_count_next < icmp_echo_pkg::MinBytes) ||
                         (byte_count_next < total_length_next);
    push_data.dest_ok  = dest_match_next;
    push_data.is_echo  = (protocol_byte_next == icmp_echo_pkg::IcmpProto) &&
                         (icmp_type_byte_next == icmp_echo_pkg::EchoRequest);
    push_data.hdr_sum  = header_sum_next;
    push_data.hdr_csum = header_csum_next;
    push_data.icmp_sum = icmp_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr <= icmp_echo_pkg::LocalAddrReset;
    end else if (cfg_wr_en) begin
      local_addr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && in_last)) begin
      byte_count     <= '0;
      header_sum     <= '0;
      icmp_sum       <= '0;
      high_byte_hold <= '0;
      dest_match     <= 1'b1;
      protocol_byte  <= '0;
      icmp_type_byte <= '0;
      total_length   <= '0;
      header_csum    <= '0;
    end else if (take) begin
      byte_count     <= byte_count_next;
      header_sum     <= header_sum_next;
      icmp_sum       <= icmp_sum_next;
      high_byte_hold <= high_byte_hold_next;
      dest_match     <= dest_match_next;
      protocol_byte  <= protocol_byte_next;
      icmp_type_byte <= icmp_type_byte_next;
      total_length   <= total_length_next;
      header_csum    <= header_csum_next;
    end
  end

endmodule

// File: rtl/icmp_echo_queue.sv
module icmp_echo_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  icmp_echo_pkg::pkt_summary_t push_data,
  output logic                        full,
  input  logic                        pop,
  output icmp_echo_pkg::pkt_summary_t pop_data,
  output logic                        empty
);

  icmp_echo_pkg::pkt_summary_t entries [icmp_echo_pkg::QueueDepth];
  logic [icmp_echo_pkg::QueuePtrW-1:0] wr_ptr;
  logic [icmp_echo_pkg::QueuePtrW-1:0] rd_ptr;
  logic [icmp_echo_pkg::QueuePtrW:0]   count;

  localparam logic [icmp_echo_pkg::QueuePtrW:0] Depth =
    (icmp_echo_pkg::QueuePtrW+1)'(icmp_echo_pkg::QueueDepth);

  assign full     = (count == Depth);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/icmp_echo_back.sv
module icmp_echo_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  icmp_echo_pkg::pkt_summary_t q_data,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  status,
  output logic [15:0]                 ip_checksum,
  output logic [15:0]                 icmp_checksum
);

  logic [2:0]  status_next;
  logic [15:0] hdr_check;

  assign pop       = !q_empty && (!out_valid || out_ready);
  assign hdr_check = icmp_echo_pkg::fold16({12'b0, q_data.hdr_sum} + {16'b0, q_data.hdr_csum});

  always_comb begin
    if (q_data.len_err) begin
      status_next = icmp_echo_pkg::StLengthErr;
    end else if (hdr_check != icmp_echo_pkg::OnesAllSet) begin
      status_next = icmp_echo_pkg::StBadHdrCsum;
    end else if (!q_data.dest_ok) begin
      status_next = icmp_echo_pkg::StWrongDest;
    end else if (q_data.is_echo) begin
      status_next = icmp_echo_pkg::StEchoReply;
    end else begin
      status_next = icmp_echo_pkg::StAccepted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Address swap leaves the header sum unchanged
  always_ff @(posedge clk) begin
    if (pop) begin
      status <= status_next;
      if (status_next == icmp_echo_pkg::StEchoReply) begin
        ip_checksum   <= ~icmp_echo_pkg::fold16({12'b0, q_data.hdr_sum});
        icmp_checksum <= ~icmp_echo_pkg::fold16(q_data.icmp_sum);
      end else begin
        ip_checksum   <= '0;
        icmp_checksum <= '0;
      end
    end
  end

endmodule

// File: rtl/ipv4_icmp_echo_responder.sv
// Throughput: one byte per cycle while the queue has room, one verdict per packet.
// m_axis_tvalid rises when the back end pops a summary into its verdict registers.
// The front accumulators take one byte per cycle while the two-entry summary queue has
// room; the queue lets verdicts wait on m_axis_tready while the next packet streams in.
// Reset (rst, synchronous): clear the accumulators, empty the queue, drop any pending
// verdict and load local_addr with 10.0.0.2.
module ipv4_icmp_echo_responder (
  input  logic        clk,
  input  logic        rst,
  // Local address register
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // Packet bytes in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last byte of the packet
  // Verdicts out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [2:0] status, [18:3] ip_checksum,
                                      // [34:19] icmp_checksum, [39:35] zero
);

  icmp_echo_pkg::pkt_summary_t push_data;
  icmp_echo_pkg::pkt_summary_t pop_data;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  logic [2:0]  status;
  logic [15:0] ip_checksum;
  logic [15:0] icmp_checksum;

  // Front: accumulate header and ICMP sums per byte, push a summary on the last byte
  icmp_echo_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  // Hold packet summaries until the back end can take them
  icmp_echo_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Back: fold the sums, rank the checks and register the verdict transfer
  icmp_echo_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .status        (status),
    .ip_checksum   (ip_checksum),
    .icmp_checksum (icmp_checksum)
  );

  assign m_axis_tdata = {5'b0, icmp_checksum, ip_checksum, status};

endmodule
